// ===== sv/olar_pkg.sv =====
// Shared types and constants for the ordered list append/remove unit.
// Used by olar_ctrl, olar_dp and the top level; no dependencies.
package olar_pkg;

    // Default list capacity
    localparam int OLAR_DEPTH = 32;

    // Field widths
    localparam int OP_W  = 2;
    localparam int VAL_W = 32;
    localparam int ST_W  = 2;

    // Operation codes
    localparam logic [OP_W-1:0] OP_APPEND = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
    localparam logic [OP_W-1:0] OP_DUMP   = 2'd2;

    // Result status codes
    localparam logic [ST_W-1:0] ST_OK        = 2'd0;
    localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL      = 2'd2;
    localparam logic [ST_W-1:0] ST_EMPTY     = 2'd3;

    // Controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_RESP,
        S_SEARCH,
        S_SHIFT,
        S_DUMP
    } t_state;

    // RAM read address select
    typedef enum logic [1:0] {
        RD_ZERO,
        RD_IDX,
        RD_NEXT,
        RD_NEXT2
    } t_rd_sel;

    // RAM write select: tail with input value, or cursor with read data
    typedef enum logic {
        WR_TAIL,
        WR_IDX
    } t_wr_sel;

    // Controller to datapath commands
    typedef struct packed {
        logic            accept;
        logic            ram_we;
        t_wr_sel         wr_sel;
        t_rd_sel         rd_sel;
        logic            idx_inc;
        logic            cnt_inc;
        logic            cnt_dec;
        logic            out_load;
        logic [ST_W-1:0] out_status;
        logic            out_elem;
        logic            out_last;
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            full;
        logic            empty;
        logic            match;
        logic            idx_last;
        logic            idx_last2;
        logic            out_free;
    } t_dp_stat;

endpackage

// ===== sv/olar_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module olar_ram #(
    parameter int W     = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [W-1:0]             i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [W-1:0]             o_rdata
);

    logic [W-1:0] r_mem [DEPTH];
    logic [W-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/olar_dp.sv =====
// Datapath: input latch, list storage, cursor, fill count and output register.
// Depends on olar_pkg and olar_ram.
module olar_dp
    import olar_pkg::*;
#(
    parameter int DEPTH = OLAR_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [OP_W-1:0]   i_op,
    input  logic [VAL_W-1:0]  i_value,
    input  t_dp_cmd           i_cmd,
    output t_dp_stat          o_stat,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    output logic [ST_W-1:0]   o_out_status,
    output logic [VAL_W-1:0]  o_out_element,
    output logic              o_out_last
);

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int NW = CW + 1;

    logic [OP_W-1:0]  r_op;
    logic [VAL_W-1:0] r_val;
    logic [IW-1:0]    r_idx;
    logic [CW-1:0]    r_cnt;
    logic             r_out_valid;
    logic [ST_W-1:0]  r_out_status;
    logic [VAL_W-1:0] r_out_element;
    logic             r_out_last;

    logic [NW-1:0]    idx_p1;
    logic [NW-1:0]    idx_p2;
    logic [NW-1:0]    cnt_ext;
    logic [NW-1:0]    rd_full;
    logic [IW-1:0]    rd_addr;
    logic [IW-1:0]    wr_addr;
    logic [VAL_W-1:0] wr_data;
    logic [VAL_W-1:0] rd_data;
    logic             out_free;

    assign idx_p1  = NW'(r_idx) + NW'(1);
    assign idx_p2  = NW'(r_idx) + NW'(2);
    assign cnt_ext = NW'(r_cnt);

    // Read address select, parked at zero past the end of the array
    always_comb begin
        case (i_cmd.rd_sel)
            RD_ZERO:  rd_full = '0;
            RD_IDX:   rd_full = NW'(r_idx);
            RD_NEXT:  rd_full = idx_p1;
            RD_NEXT2: rd_full = idx_p2;
            default:  rd_full = '0;
        endcase
        if (rd_full >= NW'(DEPTH)) begin
            rd_addr = '0;
        end else begin
            rd_addr = rd_full[IW-1:0];
        end
    end

    // Write select: append at tail, or shift an entry down one place
    always_comb begin
        if (i_cmd.wr_sel == WR_TAIL) begin
            wr_addr = r_cnt[IW-1:0];
            wr_data = r_val;
        end else begin
            wr_addr = r_idx;
            wr_data = rd_data;
        end
    end

    olar_ram #(
        .W     (VAL_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.ram_we),
        .i_waddr (wr_addr),
        .i_wdata (wr_data),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    // Input latch and cursor
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op  <= i_op;
            r_val <= i_value;
            r_idx <= '0;
        end else if (i_cmd.idx_inc) begin
            r_idx <= r_idx + IW'(1);
        end
    end

    // Fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.cnt_inc) begin
            r_cnt <= r_cnt + CW'(1);
        end else if (i_cmd.cnt_dec) begin
            r_cnt <= r_cnt - CW'(1);
        end
    end

    assign out_free = !r_out_valid || i_out_ready;

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_status  <= i_cmd.out_status;
            r_out_element <= i_cmd.out_elem ? rd_data : '0;
            r_out_last    <= i_cmd.out_last;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_status  = r_out_status;
    assign o_out_element = r_out_element;
    assign o_out_last    = r_out_last;

    // Status back to the controller
    assign o_stat.op        = r_op;
    assign o_stat.full      = (cnt_ext == NW'(DEPTH));
    assign o_stat.empty     = (r_cnt == '0);
    assign o_stat.match     = (rd_data == r_val);
    assign o_stat.idx_last  = (idx_p1 == cnt_ext);
    assign o_stat.idx_last2 = (idx_p2 == cnt_ext);
    assign o_stat.out_free  = out_free;

endmodule

// ===== sv/olar_ctrl.sv =====
// Controller: sequences append, search-and-shift remove and dump.
// Depends on olar_pkg.
module olar_ctrl
    import olar_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    t_state          r_state;
    t_state          n_state;
    logic [ST_W-1:0] r_resp;
    logic [ST_W-1:0] n_resp;

    // State and pending status register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_resp  <= ST_OK;
        end else begin
            r_state <= n_state;
            r_resp  <= n_resp;
        end
    end

    // Next state and datapath commands
    always_comb begin
        n_state          = r_state;
        n_resp           = r_resp;
        o_in_ready       = 1'b0;
        o_cmd            = '0;
        o_cmd.wr_sel     = WR_TAIL;
        o_cmd.rd_sel     = RD_IDX;
        o_cmd.out_status = ST_OK;

        case (r_state)
            S_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_DECODE;
                end
            end

            S_DECODE: begin
                case (i_stat.op)
                    OP_APPEND: begin
                        n_state = S_RESP;
                        if (i_stat.full) begin
                            n_resp = ST_FULL;
                        end else begin
                            o_cmd.ram_we  = 1'b1;
                            o_cmd.wr_sel  = WR_TAIL;
                            o_cmd.cnt_inc = 1'b1;
                            n_resp        = ST_OK;
                        end
                    end
                    OP_REMOVE: begin
                        if (i_stat.empty) begin
                            n_resp  = ST_EMPTY;
                            n_state = S_RESP;
                        end else begin
                            o_cmd.rd_sel = RD_ZERO;
                            n_state      = S_SEARCH;
                        end
                    end
                    OP_DUMP: begin
                        if (i_stat.empty) begin
                            n_resp  = ST_EMPTY;
                            n_state = S_RESP;
                        end else begin
                            o_cmd.rd_sel = RD_ZERO;
                            n_state      = S_DUMP;
                        end
                    end
                    default: begin
                        // unused opcode: dropped without a result
                        n_state = S_IDLE;
                    end
                endcase
            end

            S_RESP: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load   = 1'b1;
                    o_cmd.out_status = r_resp;
                    o_cmd.out_last   = 1'b1;
                    n_state          = S_IDLE;
                end
            end

            // One entry compared per cycle, head first
            S_SEARCH: begin
                if (i_stat.match) begin
                    if (i_stat.idx_last) begin
                        o_cmd.cnt_dec = 1'b1;
                        n_resp        = ST_OK;
                        n_state       = S_RESP;
                    end else begin
                        o_cmd.rd_sel = RD_NEXT;
                        n_state      = S_SHIFT;
                    end
                end else if (i_stat.idx_last) begin
                    n_resp  = ST_NOT_FOUND;
                    n_state = S_RESP;
                end else begin
                    o_cmd.rd_sel  = RD_NEXT;
                    o_cmd.idx_inc = 1'b1;
                end
            end

            // Close the gap: entry idx+1 moves to idx, one per cycle
            S_SHIFT: begin
                o_cmd.ram_we  = 1'b1;
                o_cmd.wr_sel  = WR_IDX;
                o_cmd.idx_inc = 1'b1;
                if (i_stat.idx_last2) begin
                    o_cmd.cnt_dec = 1'b1;
                    n_resp        = ST_OK;
                    n_state       = S_RESP;
                end else begin
                    o_cmd.rd_sel = RD_NEXT2;
                end
            end

            // Stream entries; hold the read address while the output stalls
            S_DUMP: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load   = 1'b1;
                    o_cmd.out_status = ST_OK;
                    o_cmd.out_elem   = 1'b1;
                    o_cmd.out_last   = i_stat.idx_last;
                    if (i_stat.idx_last) begin
                        o_cmd.rd_sel = RD_ZERO;
                        n_state      = S_IDLE;
                    end else begin
                        o_cmd.rd_sel  = RD_NEXT;
                        o_cmd.idx_inc = 1'b1;
                    end
                end else begin
                    o_cmd.rd_sel = RD_IDX;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== sv/ordered_list_append_remove_unit.sv =====
// Ordered list unit: append at tail, remove first equal value, dump head to tail.
// Remove compares entries one at a time from the head, then shifts each later entry down
// one place; an absent value is compared against every entry before its result.
// Throughput: one item at a time; the next is taken the cycle after its last result
// loads (dump: one entry per cycle); output stalls hold it.
// Reset (synchronous, active low) empties the list; the RAM needs no clearing.
module ordered_list_append_remove_unit
    import olar_pkg::*;
#(
    parameter int DEPTH = OLAR_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [VAL_W-1:0]  s_axis_tdata,   // [31:0] value
    input  logic [OP_W-1:0]   s_axis_tuser,   // [1:0] opcode
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [VAL_W-1:0]  m_axis_tdata,   // [31:0] element
    output logic [ST_W-1:0]   m_axis_tuser,   // [1:0] status
    output logic              m_axis_tlast
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    olar_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    olar_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_op          (s_axis_tuser),
        .i_value       (s_axis_tdata),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_out_ready   (m_axis_tready),
        .o_out_valid   (m_axis_tvalid),
        .o_out_status  (m_axis_tuser),
        .o_out_element (m_axis_tdata),
        .o_out_last    (m_axis_tlast)
    );

    // A pending result is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> stat.out_free)
        else $error("output register loaded while a result is pending");

    // No storage write while waiting for a new item
    a_idle_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> !cmd.ram_we)
        else $error("RAM written while idle");

    // Count never grows past capacity
    a_no_overfill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.cnt_inc |-> !stat.full)
        else $error("append while full");

    // Output channel is empty right after reset
    a_reset_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !m_axis_tvalid)
        else $error("result valid after reset");

endmodule
